// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/hsps_pkg.sv
// ----------------------------------------------------------------------------
// hsps_pkg
// shared widths, codes and constants of the sensor poll sequencer
// ----------------------------------------------------------------------------
package hsps_pkg;

  // default timing
  localparam int TICK_MS_DEF = 5;
  localparam int WAIT_MS_DEF = 80;

  // field widths
  localparam int CMD_W   = 3;
  localparam int PHASE_W = 2;
  localparam int RC_W    = 2;
  localparam int HUM_W   = 14;
  localparam int TEMP_W  = 15;
  localparam int CNT_W   = 16;
  localparam int RAW_W   = 20;

  localparam logic [CNT_W-1:0] INTERVAL_RESET = 16'd100;

  // sensor status bits
  localparam int STAT_BUSY_BIT = 7;
  localparam int STAT_CAL_BIT  = 3;

  // bus commands
  localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INIT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TRIG = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SRST = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

  // reported phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_READY = 2'd2;
  localparam logic [PHASE_W-1:0] PH_ERROR = 2'd3;

  // result codes
  localparam logic [RC_W-1:0] RC_OK    = 2'd0;
  localparam logic [RC_W-1:0] RC_BUS   = 2'd1;
  localparam logic [RC_W-1:0] RC_BUSY  = 2'd2;
  localparam logic [RC_W-1:0] RC_NOCAL = 2'd3;

  // conversion scales, raw values are 20-bit fractions of full scale
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [15:0] TEMP_OFFSET = 16'd5000;

endpackage

// File: hw/rtl/hsps_if.sv
// ----------------------------------------------------------------------------
// hsps channel interfaces
// valid/ready channels for step beats, report beats and config writes
// ----------------------------------------------------------------------------
interface hsps_step_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic       write_ok;
  logic       status_ok;
  logic [7:0] status_byte;
  logic       data_ok;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic [7:0] byte_four;
  logic [7:0] byte_five;

  modport source (
    output valid, action, write_ok, status_ok, status_byte, data_ok,
           byte_one, byte_two, byte_three, byte_four, byte_five,
    input  ready
  );
  modport sink (
    input  valid, action, write_ok, status_ok, status_byte, data_ok,
           byte_one, byte_two, byte_three, byte_four, byte_five,
    output ready
  );
endinterface

interface hsps_report_if;
  logic                                valid;
  logic                                ready;
  logic [hsps_pkg::CMD_W-1:0]          bus_command;
  logic [hsps_pkg::PHASE_W-1:0]        phase;
  logic [hsps_pkg::RC_W-1:0]           result_code;
  logic [hsps_pkg::HUM_W-1:0]          humidity_centi;
  logic signed [hsps_pkg::TEMP_W-1:0]  temperature_centi;

  modport source (
    output valid, bus_command, phase, result_code, humidity_centi, temperature_centi,
    input  ready
  );
  modport sink (
    input  valid, bus_command, phase, result_code, humidity_centi, temperature_centi,
    output ready
  );
endinterface

interface hsps_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [hsps_pkg::CNT_W-1:0]   interval_ms;

  modport source (output valid, interval_ms, input ready);
  modport sink (input valid, interval_ms, output ready);
endinterface

// File: hw/rtl/humidity_sensor_poll_sequencer.sv
// a step beat is accepted into the input register, and its report beat turns valid in the report register
// throughput: one step beat per cycle while the report is not stalled, set by the state update
//   between the input register and the report register
// a stalled report holds its beat while one more step beat waits in the input register
// reset (rst, synchronous, active high): phase idle, tick count and readings zero,
//   interval back to 100, both pipeline registers empty
// ----------------------------------------------------------------------------
// humidity_sensor_poll_sequencer
// polls a temperature and humidity sensor one step beat at a time
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module humidity_sensor_poll_sequencer #(
  parameter int TICK_MS = hsps_pkg::TICK_MS_DEF,
  parameter int WAIT_MS = hsps_pkg::WAIT_MS_DEF
) (
  input logic            clk,
  input logic            rst,
  hsps_step_if.sink      step,
  hsps_report_if.source  report,
  hsps_cfg_if.sink       cfg
);

  localparam int CntW = hsps_pkg::CNT_W;
  // (count + 1) * TICK_MS needs one bit for the +1 and the bits of TICK_MS
  localparam int LimW = CntW + 1 + $clog2(TICK_MS + 1);
  localparam logic [CntW-1:0] WaitTicks = CntW'(WAIT_MS / TICK_MS);
  localparam logic [LimW-1:0] TickLen   = LimW'(TICK_MS);

  // internal one-hot phase register
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WAIT  = 4'b0010,
    ST_READY = 4'b0100,
    ST_ERROR = 4'b1000
  } phase_st_t;

  function automatic logic [hsps_pkg::PHASE_W-1:0] phase_code(input phase_st_t st);
    logic [hsps_pkg::PHASE_W-1:0] code;
    case (st)
      ST_IDLE:  code = hsps_pkg::PH_IDLE;
      ST_WAIT:  code = hsps_pkg::PH_WAIT;
      ST_READY: code = hsps_pkg::PH_READY;
      default:  code = hsps_pkg::PH_ERROR;
    endcase
    return code;
  endfunction

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic       s1_valid;
  logic       s1_action;
  logic       s1_write_ok;
  logic       s1_status_ok;
  logic [7:0] s1_status;
  logic       s1_data_ok;
  logic [7:0] s1_b1, s1_b2, s1_b3, s1_b4, s1_b5;

  // --------------------------------------------------------------------------
  // block state
  // --------------------------------------------------------------------------
  phase_st_t                             phase_st;
  logic [CntW-1:0]                       tick_count;
  logic [hsps_pkg::HUM_W-1:0]            humidity_reg;
  logic signed [hsps_pkg::TEMP_W-1:0]    temperature_reg;
  logic [CntW-1:0]                       interval;

  // --------------------------------------------------------------------------
  // report register
  // --------------------------------------------------------------------------
  logic                                  rpt_valid;
  logic [hsps_pkg::CMD_W-1:0]            rpt_cmd;
  logic [hsps_pkg::PHASE_W-1:0]          rpt_phase;
  logic [hsps_pkg::RC_W-1:0]             rpt_rc;
  logic [hsps_pkg::HUM_W-1:0]            rpt_hum;
  logic signed [hsps_pkg::TEMP_W-1:0]    rpt_temp;

  // the held beat moves on when the report register is empty or being drained
  logic s1_adv;
  assign s1_adv     = s1_valid && (!rpt_valid || report.ready);
  assign step.ready = !s1_valid || s1_adv;
  assign cfg.ready  = 1'b1;

  // --------------------------------------------------------------------------
  // raw value unpack and fixed point conversion
  // --------------------------------------------------------------------------
  logic [hsps_pkg::RAW_W-1:0] hum_raw;
  logic [hsps_pkg::RAW_W-1:0] temp_raw;
  logic [33:0]                hum_prod;
  logic [34:0]                temp_prod;
  logic [15:0]                temp_diff;
  logic [hsps_pkg::HUM_W-1:0]         hum_conv;
  logic signed [hsps_pkg::TEMP_W-1:0] temp_conv;

  assign hum_raw   = {s1_b1, s1_b2, s1_b3[7:4]};
  assign temp_raw  = {s1_b3[3:0], s1_b4, s1_b5};
  // floor(raw * scale / 2^20) is the top bits of the product
  assign hum_prod  = 34'(hum_raw) * 34'(hsps_pkg::HUM_SCALE);
  assign temp_prod = 35'(temp_raw) * 35'(hsps_pkg::TEMP_SCALE);
  assign hum_conv  = hum_prod[33:20];
  // 0..19999 minus 5000 always lands in the signed 15-bit range
  assign temp_diff = {1'b0, temp_prod[34:20]} - hsps_pkg::TEMP_OFFSET;
  assign temp_conv = $signed(temp_diff[14:0]);

  // --------------------------------------------------------------------------
  // tick counting
  // --------------------------------------------------------------------------
  logic [CntW-1:0] cnt_inc;
  logic [LimW-1:0] ready_span;
  logic            ready_done;

  // saturating increment
  assign cnt_inc    = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  // count >= interval / TICK_MS  <=>  (count + 1) * TICK_MS > interval
  assign ready_span = (LimW'(cnt_inc) + LimW'(1)) * TickLen;
  assign ready_done = ready_span > LimW'(interval);

  // --------------------------------------------------------------------------
  // step logic
  // --------------------------------------------------------------------------
  phase_st_t                          phase_next;
  logic [CntW-1:0]                    tick_next;
  logic [hsps_pkg::HUM_W-1:0]         hum_next;
  logic signed [hsps_pkg::TEMP_W-1:0] temp_next;
  logic [CntW-1:0]                    interval_next;
  logic [hsps_pkg::CMD_W-1:0]         cmd;
  logic [hsps_pkg::RC_W-1:0]          rc;

  always_comb begin
    phase_next    = phase_st;
    tick_next     = tick_count;
    hum_next      = humidity_reg;
    temp_next     = temperature_reg;
    interval_next = interval;
    cmd           = hsps_pkg::CMD_NONE;
    rc            = hsps_pkg::RC_OK;
    if (s1_action) begin
      // initialize request works from any phase and wipes the readings
      interval_next = hsps_pkg::INTERVAL_RESET;
      tick_next     = '0;
      hum_next      = '0;
      temp_next     = '0;
      cmd           = hsps_pkg::CMD_INIT;
      if (!s1_write_ok || !s1_status_ok) begin
        phase_next = ST_ERROR;
        rc         = hsps_pkg::RC_BUS;
      end else if (!s1_status[hsps_pkg::STAT_CAL_BIT]) begin
        phase_next = ST_ERROR;
        rc         = hsps_pkg::RC_NOCAL;
      end else begin
        phase_next = ST_IDLE;
      end
    end else begin
      case (phase_st)
        ST_IDLE: begin
          // kick off a measurement
          cmd = hsps_pkg::CMD_TRIG;
          if (s1_write_ok) begin
            phase_next = ST_WAIT;
            tick_next  = '0;
          end else begin
            rc = hsps_pkg::RC_BUS;
          end
        end
        ST_WAIT: begin
          tick_next = cnt_inc;
          if (cnt_inc >= WaitTicks) begin
            cmd = hsps_pkg::CMD_READ;
            if (!s1_status_ok) begin
              rc = hsps_pkg::RC_BUS;
            end else if (s1_status[hsps_pkg::STAT_BUSY_BIT]) begin
              rc = hsps_pkg::RC_BUSY;
            end else if (!s1_data_ok) begin
              rc = hsps_pkg::RC_BUS;
            end else begin
              // good read, count keeps running into ready
              hum_next   = hum_conv;
              temp_next  = temp_conv;
              phase_next = ST_READY;
            end
          end
        end
        ST_READY: begin
          tick_next = cnt_inc;
          if (ready_done) begin
            phase_next = ST_IDLE;
            tick_next  = '0;
          end
        end
        default: begin
          // error phase (and any stray encoding): try a soft reset
          cmd = hsps_pkg::CMD_SRST;
          if (s1_write_ok) begin
            phase_next = ST_IDLE;
          end else begin
            rc = hsps_pkg::RC_BUS;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      rpt_valid       <= 1'b0;
      phase_st        <= ST_IDLE;
      tick_count      <= '0;
      humidity_reg    <= '0;
      temperature_reg <= '0;
      interval        <= hsps_pkg::INTERVAL_RESET;
    end else begin
      if (step.ready) begin
        s1_valid <= step.valid;
      end
      if (s1_adv) begin
        rpt_valid <= 1'b1;
      end else if (report.ready) begin
        rpt_valid <= 1'b0;
      end
      if (s1_adv) begin
        phase_st        <= phase_next;
        tick_count      <= tick_next;
        humidity_reg    <= hum_next;
        temperature_reg <= temp_next;
      end
      // the user must send config writes only while the block is quiet; the block itself does not enforce it
      if (cfg.valid && cfg.ready) begin
        interval <= cfg.interval_ms;
      end else if (s1_adv) begin
        interval <= interval_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (step.valid && step.ready) begin
      s1_action    <= step.action;
      s1_write_ok  <= step.write_ok;
      s1_status_ok <= step.status_ok;
      s1_status    <= step.status_byte;
      s1_data_ok   <= step.data_ok;
      s1_b1        <= step.byte_one;
      s1_b2        <= step.byte_two;
      s1_b3        <= step.byte_three;
      s1_b4        <= step.byte_four;
      s1_b5        <= step.byte_five;
    end
    if (s1_adv) begin
      rpt_cmd   <= cmd;
      rpt_phase <= phase_code(phase_next);
      rpt_rc    <= rc;
      rpt_hum   <= hum_next;
      rpt_temp  <= temp_next;
    end
  end

  assign report.valid             = rpt_valid;
  assign report.bus_command       = rpt_cmd;
  assign report.phase             = rpt_phase;
  assign report.result_code       = rpt_rc;
  assign report.humidity_centi    = rpt_hum;
  assign report.temperature_centi = rpt_temp;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_init_clears, clk, rst, s1_adv && s1_action,
    tick_count == '0 && interval == hsps_pkg::INTERVAL_RESET && rpt_cmd == hsps_pkg::CMD_INIT)

  `ASSERT_NEXT(a_trig_fail, clk, rst,
    s1_adv && !s1_action && phase_st == ST_IDLE && !s1_write_ok,
    rpt_cmd == hsps_pkg::CMD_TRIG && rpt_rc == hsps_pkg::RC_BUS && phase_st == ST_IDLE)

  `ASSERT_ALWAYS(a_busy_in_wait, clk, rst,
    rpt_valid && rpt_rc == hsps_pkg::RC_BUSY |->
      rpt_cmd == hsps_pkg::CMD_READ && rpt_phase == hsps_pkg::PH_WAIT)

  `ASSERT_ALWAYS(a_hum_range, clk, rst, humidity_reg <= 14'd9999)

endmodule
